// ===== hdl/mpo_pkg.sv =====
// Shared codes, constants and the noise step of the multiwave phase oscillator.
package mpo_pkg;

	// Wave type codes held in the wave_type register.
	localparam logic [2:0] WAVE_RAMP_UP   = 3'd0;
	localparam logic [2:0] WAVE_RAMP_DOWN = 3'd1;
	localparam logic [2:0] WAVE_SQUARE    = 3'd2;
	localparam logic [2:0] WAVE_TRIANGLE  = 3'd3;
	localparam logic [2:0] WAVE_SH        = 3'd4;

	// Configuration register indexes.
	localparam logic REG_WAVE_TYPE = 1'b0;
	localparam logic REG_FREQ_WORD = 1'b1;

	localparam int WAVE_W   = 3;
	localparam int FREQ_W   = 24;
	localparam int SAMPLE_W = 12;

	localparam logic [31:0] NOISE_SEED = 32'hDEADBEEF;

	// One xorshift32 step.
	function automatic logic [31:0] xorshift32(input logic [31:0] x);
		logic [31:0] a;
		logic [31:0] b;
		a = x ^ (x << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

endpackage

// ===== hdl/mpo_wave.sv =====
// Waveform shaper: maps a phase and a wave type to a saw, square or triangle sample.
module mpo_wave #(
	parameter int PHASE_BITS = 24,
	parameter int LEVEL_BITS = 12
) (
	input  logic [PHASE_BITS-1:0]       phase,
	input  logic [mpo_pkg::WAVE_W-1:0]  wave_type,
	output logic [LEVEL_BITS-1:0]       value
);

	logic [31:0]           aligned;
	logic [31:0]           folded;
	logic [LEVEL_BITS-1:0] saw;
	logic [LEVEL_BITS-1:0] tri_v;

	// Left-align the phase in a 32-bit word.
	assign aligned = {phase, {(32-PHASE_BITS){1'b0}}};
	assign saw     = aligned[31 -: LEVEL_BITS];
	// Fold about the MSB.
	assign folded  = aligned[31] ? ~aligned : aligned;
	assign tri_v   = folded[30 -: LEVEL_BITS];

	always_comb begin
		case (wave_type)
			mpo_pkg::WAVE_RAMP_DOWN: value = ~saw;
			mpo_pkg::WAVE_SQUARE:    value = {LEVEL_BITS{aligned[31]}};
			mpo_pkg::WAVE_TRIANGLE:  value = tri_v;
			default:                 value = saw;
		endcase
	end

endmodule

// ===== hdl/multiwave_phase_oscillator.sv =====
// Top level of the multiwave phase oscillator: phase accumulator, noise S&H, result register.
//
//  channel | direction | signals                                  | payload
//  --------+-----------+------------------------------------------+------------------------------
//  s_      | in        | s_tvalid s_tready s_tdata[7:0]           | tick
//  m_      | out       | m_tvalid m_tready m_tdata[15:0]          | sample
//  cfg_    | in        | cfg_valid cfg_ready cfg_index cfg_data   | wave_type (0), freq_word (1)
//
// One beat in, one beat out; a sample appears in the cycle after its tick beat is taken,
// and a new beat is accepted every cycle while the result register drains. The whole step
// (waveform shaping, one xorshift step, one accumulator add) sits between the state
// registers and the single result register. s_tready drops only while a result waits
// on m_tready. Configuration writes are always taken. Reset clears phase, held sample and
// previous phase, loads the noise generator with its seed and empties the result register.
module multiwave_phase_oscillator #(
	parameter int PHASE_BITS = 24,
	parameter int LEVEL_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] tick, [7:1] zero
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [11:0] sample, [15:12] zero
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);

	logic [mpo_pkg::WAVE_W-1:0] wave_type_q;
	logic [mpo_pkg::FREQ_W-1:0] freq_word_q;
	logic [PHASE_BITS-1:0]      phase_q;
	logic [PHASE_BITS-1:0]      prev_phase_q;
	logic [LEVEL_BITS-1:0]      held_q;
	logic [31:0]                noise_q;

	logic                       out_valid_q;
	logic [mpo_pkg::SAMPLE_W-1:0] out_sample_q;

	logic                       in_beat;
	logic                       tick;
	logic                       is_sh;
	logic                       wrapped;
	logic [31:0]                noise_next;
	logic [LEVEL_BITS-1:0]      plain;
	logic [LEVEL_BITS-1:0]      held_next;
	logic [LEVEL_BITS-1:0]      result;
	logic [31:0]                freq_ext;
	logic [31:0]                result_ext;

	assign cfg_ready = 1'b1;
	// Take a new beat whenever the result register is empty or draining.
	assign s_tready  = !out_valid_q || m_tready;
	assign in_beat   = s_tvalid && s_tready;
	assign tick      = s_tdata[0];
	assign is_sh     = (wave_type_q == mpo_pkg::WAVE_SH);

	mpo_wave #(
		.PHASE_BITS(PHASE_BITS),
		.LEVEL_BITS(LEVEL_BITS)
	) u_wave (
		.phase    (phase_q),
		.wave_type(wave_type_q),
		.value    (plain)
	);

	// A wrap shows up as the phase falling below the one seen at the last S&H tick.
	assign wrapped    = phase_q < prev_phase_q;
	assign noise_next = mpo_pkg::xorshift32(noise_q);

	always_comb begin
		held_next = held_q;
		if (tick) begin
			if (is_sh) begin
				if (wrapped) begin
					held_next = noise_next[LEVEL_BITS-1:0];
				end
			end else begin
				held_next = plain;
			end
		end
	end

	// S&H reports the (possibly refreshed) held sample, other waves the shaped one.
	assign result     = is_sh ? held_next : plain;
	assign result_ext = 32'(result);
	assign freq_ext   = 32'(freq_word_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_type_q <= mpo_pkg::WAVE_RAMP_UP;
			freq_word_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mpo_pkg::REG_WAVE_TYPE: wave_type_q <= cfg_data[mpo_pkg::WAVE_W-1:0];
				mpo_pkg::REG_FREQ_WORD: freq_word_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Oscillator state: advance only on a tick beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			prev_phase_q <= '0;
			held_q       <= '0;
			noise_q      <= mpo_pkg::NOISE_SEED;
		end else if (in_beat && tick) begin
			phase_q <= phase_q + freq_ext[PHASE_BITS-1:0];
			held_q  <= held_next;
			if (is_sh) begin
				prev_phase_q <= phase_q;
				if (wrapped) begin
					noise_q <= noise_next;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_beat) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			out_sample_q <= result_ext[mpo_pkg::SAMPLE_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_sample_q};

endmodule

// ===== hdl/mpo_checker.sv =====
// Port-level checks for the multiwave phase oscillator, bound to its top level.
module mpo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	logic s_beat;
	assign s_beat = s_tvalid && s_tready;

	// A waiting result blocks new input beats.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input beat taken while result stalled");

	// Every input beat yields a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat |=> m_tvalid)
		else $error("no result after input beat");

	// No result appears without an input beat.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid && !s_beat) |=> !m_tvalid)
		else $error("result without input beat");

	// Padding bits of the output beat stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:12] == 4'b0000))
		else $error("output padding not zero");

	// Stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind multiwave_phase_oscillator mpo_checker u_mpo_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== verif/multiwave_phase_oscillator_test.sv =====
// Self-checking testbench for the multiwave phase oscillator: directed table, then random phases.
module multiwave_phase_oscillator_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [mpo_pkg::WAVE_W-1:0]   wave_t;
	typedef logic [mpo_pkg::FREQ_W-1:0]   freq_t;
	typedef logic [mpo_pkg::SAMPLE_W-1:0] sample_t;

	// Wave codes outside the named set; the block treats them as saw up.
	localparam wave_t WAVE_SPARE_LO = 3'd5;
	localparam wave_t WAVE_SPARE_HI = 3'd7;
	localparam freq_t FREQ_MAX      = '1;
	localparam freq_t FREQ_HALF     = 24'h800000;
	localparam int RANDOM_BEATS   = 1800;
	localparam int STALL_CYCLES   = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;   // [0] tick, [7:1] zero
	logic                m_tvalid;
	logic                m_tready;
	logic [15:0]         m_tdata;   // [11:0] sample, [15:12] zero
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_index;
	freq_t               cfg_data;

	multiwave_phase_oscillator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Oscillator state as the block should hold it.
	wave_t               osc_wave  = mpo_pkg::WAVE_RAMP_UP;
	freq_t               osc_freq  = '0;
	freq_t               osc_phase = '0;
	freq_t               osc_prev  = '0;
	sample_t             osc_held  = '0;
	logic [31:0]         osc_noise = mpo_pkg::NOISE_SEED;

	sample_t             pending_samples[$];
	int                  fault_count  = 0;
	int                  samples_seen = 0;
	int                  beats_sent   = 0;
	int                  quiet_cycles = 0;
	bit                  calm = 0;   // both sides run without idling while set

	// Directed stimulus table.
	typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;
	typedef struct packed {
		row_kind_t           kind;
		logic                reg_idx;
		freq_t               value;
		logic                tick;
		logic                known;    // sample typed in by hand
		sample_t             sample;
	} plan_row_t;
	plan_row_t plan[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Work out the sample for one tick beat and move the oscillator state on.
	function automatic sample_t advance_oscillator(input logic tick);
		sample_t             s;
		logic [31:0]         x;
		if (osc_wave == mpo_pkg::WAVE_SH) begin
			if (tick) begin
				// A phase below the last S&H phase means the accumulator wrapped.
				if (osc_phase < osc_prev) begin
					x = osc_noise;
					x = x ^ (x << 13);
					x = x ^ (x >> 17);
					x = x ^ (x << 5);
					osc_noise = x;
					osc_held = x[mpo_pkg::SAMPLE_W-1:0];
				end
				osc_prev = osc_phase;
			end
			s = osc_held;
		end else begin
			case (osc_wave)
				mpo_pkg::WAVE_RAMP_DOWN: s = ~osc_phase[23:12];
				mpo_pkg::WAVE_SQUARE:    s = {mpo_pkg::SAMPLE_W{osc_phase[23]}};
				mpo_pkg::WAVE_TRIANGLE:
					s = osc_phase[23] ? ~osc_phase[22:11] : osc_phase[22:11];
				default:                 s = osc_phase[23:12];
			endcase
			if (tick) osc_held = s;
		end
		if (tick) osc_phase = osc_phase + osc_freq;
		return s;
	endfunction

	function automatic void plan_write(input logic idx, input freq_t value);
		plan_row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.reg_idx = idx;
		r.value = value;
		plan.push_back(r);
	endfunction

	function automatic void plan_beat(input logic tick, input logic known,
			input sample_t sample);
		plan_row_t r;
		r = '0;
		r.kind = ROW_BEAT;
		r.tick = tick;
		r.known = known;
		r.sample = sample;
		plan.push_back(r);
	endfunction

	// Offer one tick beat; called and returns at a falling edge, valid left high.
	task automatic send_beat(input logic tick, input logic known,
			input sample_t sample);
		sample_t predicted;
		while (!calm && $urandom_range(99) < 32) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, tick};
		do @(posedge clk); while (!s_tready);
		predicted = advance_oscillator(tick);
		pending_samples.push_back(known ? sample : predicted);
		beats_sent++;
		calm = (beats_sent >= 700 && beats_sent < 1000);
		@(negedge clk);
	endtask

	// Write one register; valid stays high so back-to-back writes need no toggle.
	task automatic write_reg(input logic idx, input freq_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == mpo_pkg::REG_WAVE_TYPE) osc_wave = value[mpo_pkg::WAVE_W-1:0];
		else osc_freq = value;
		@(negedge clk);
	endtask

	// Drop the stream valid and wait until every sample has come back.
	task automatic drain_samples();
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0) @(negedge clk);
	endtask

	function automatic freq_t pick_freq();
		case ($urandom_range(5))
			0: return $urandom_range(1) ? FREQ_MAX : '0;
			1: return freq_t'($urandom_range(255));
			2: return freq_t'($urandom());
			3: return freq_t'(FREQ_MAX - $urandom_range(255));
			default: return freq_t'($urandom_range(24'h400000, 24'h10000));
		endcase
	endfunction

	// Stimulus: directed table, then random phases of wave and frequency.
	initial begin
		logic                writing;
		wave_t               wave;
		int                  count;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = mpo_pkg::REG_WAVE_TYPE;
		cfg_data = '0;
		writing = 1'b0;

		// Reset state: phase at zero, frequency zero, saw up.
		plan_beat(1'b0, 1'b1, 12'h000);
		plan_beat(1'b1, 1'b1, 12'h000);
		// Full-scale frequency walks the phase down by one each tick.
		plan_write(mpo_pkg::REG_FREQ_WORD, FREQ_MAX);
		plan_beat(1'b1, 1'b1, 12'h000);
		plan_beat(1'b0, 1'b1, 12'hFFF);
		plan_beat(1'b1, 1'b1, 12'hFFF);
		plan_write(mpo_pkg::REG_WAVE_TYPE, freq_t'(mpo_pkg::WAVE_RAMP_DOWN));
		plan_beat(1'b0, 1'b1, 12'h000);
		plan_write(mpo_pkg::REG_WAVE_TYPE, freq_t'(mpo_pkg::WAVE_SQUARE));
		plan_beat(1'b0, 1'b1, 12'hFFF);
		plan_write(mpo_pkg::REG_WAVE_TYPE, freq_t'(mpo_pkg::WAVE_TRIANGLE));
		plan_beat(1'b0, 1'b1, 12'h000);
		// S&H first reports the sample left by the saw, then steps on a late wrap.
		plan_write(mpo_pkg::REG_WAVE_TYPE, freq_t'(mpo_pkg::WAVE_SH));
		plan_beat(1'b0, 1'b1, 12'hFFF);
		plan_beat(1'b1, 1'b1, 12'hFFF);
		plan_beat(1'b1, 1'b0, '0);
		plan_beat(1'b0, 1'b0, '0);
		// Spare wave codes read as saw up.
		plan_write(mpo_pkg::REG_WAVE_TYPE, freq_t'(WAVE_SPARE_HI));
		plan_beat(1'b0, 1'b1, 12'hFFF);
		plan_write(mpo_pkg::REG_FREQ_WORD, FREQ_HALF);
		plan_write(mpo_pkg::REG_WAVE_TYPE, freq_t'(mpo_pkg::WAVE_TRIANGLE));
		plan_beat(1'b1, 1'b1, 12'h000);
		plan_beat(1'b1, 1'b1, 12'hFFF);
		plan_write(mpo_pkg::REG_WAVE_TYPE, freq_t'(WAVE_SPARE_LO));
		plan_write(mpo_pkg::REG_FREQ_WORD, '0);
		plan_beat(1'b1, 1'b1, 12'hFFF);
		plan_beat(1'b1, 1'b1, 12'hFFF);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				if (!writing) begin
					drain_samples();
					writing = 1'b1;
				end
				write_reg(plan[i].reg_idx, plan[i].value);
			end else begin
				if (writing) begin
					cfg_valid <= 1'b0;
					writing = 1'b0;
				end
				send_beat(plan[i].tick, plan[i].known, plan[i].sample);
			end
		end

		// Random phases; S&H gets extra weight since it holds the most state.
		while (beats_sent < RANDOM_BEATS + plan.size()) begin
			drain_samples();
			wave = ($urandom_range(99) < 40) ? mpo_pkg::WAVE_SH : wave_t'($urandom_range(7));
			if ($urandom_range(1)) begin
				write_reg(mpo_pkg::REG_WAVE_TYPE, freq_t'(wave));
				write_reg(mpo_pkg::REG_FREQ_WORD, pick_freq());
			end else begin
				write_reg(mpo_pkg::REG_FREQ_WORD, pick_freq());
				write_reg(mpo_pkg::REG_WAVE_TYPE, freq_t'(wave));
			end
			cfg_valid <= 1'b0;
			count = $urandom_range(160, 40);
			repeat (count) send_beat($urandom_range(99) < 85, 1'b0, '0);
		end

		drain_samples();
		repeat (4) @(negedge clk);
		if (fault_count == 0)
			$display("[multiwave_phase_oscillator] OK");
		else
			$display("[multiwave_phase_oscillator] ERROR");
		$finish;
	end

	// Receiver: random back-pressure, plus one long hold-off to fill the block.
	initial begin
		bit stall_done;
		stall_done = 0;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			// Start the hold-off only while the sender is offering beats.
			if (!stall_done && !calm && samples_seen >= 300 && s_tvalid) begin
				m_tready <= 1'b0;
				repeat (STALL_CYCLES) @(negedge clk);
				stall_done = 1;
			end
			m_tready <= calm || ($urandom_range(99) >= 32);
		end
	end

	// Check each sample beat against the oldest prediction.
	always @(posedge clk) begin
		sample_t want;
		if (arst_n && m_tvalid && m_tready) begin
			samples_seen++;
			if (pending_samples.size() == 0) begin
				$error("sample beat with nothing expected: actual %h",
					m_tdata[mpo_pkg::SAMPLE_W-1:0]);
				fault_count++;
			end else begin
				want = pending_samples.pop_front();
				if (m_tdata[mpo_pkg::SAMPLE_W-1:0] !== want) begin
					$error("sample mismatch: expected %h actual %h",
						want, m_tdata[mpo_pkg::SAMPLE_W-1:0]);
					fault_count++;
				end
			end
		end
	end

	// Watchdog: end the run if no channel moves a beat for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[multiwave_phase_oscillator] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

// ===== multiwave_phase_oscillator.f =====
hdl/mpo_pkg.sv
hdl/mpo_wave.sv
hdl/multiwave_phase_oscillator.sv
hdl/mpo_checker.sv
verif/multiwave_phase_oscillator_test.sv
